### rtl/core/lmsr_pkg.sv
// Package for the LED matrix scroll renderer: render modes, opcodes, flag bits,
// controller states and the command and status structs between controller and datapath.
// No dependencies.
`default_nettype none

package lmsr_pkg;

   typedef enum logic [1:0] {
      MODE_EMPTY    = 2'd0,
      MODE_STABLE   = 2'd1,
      MODE_PIXEL    = 2'd2,
      MODE_RENDERED = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_READ = 2'd1,
      ST_SHOW = 2'd2
   } ctrl_state_type;

   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_LOAD   = 2'd1;
   localparam logic [1:0] OP_COMMIT = 2'd2;

   localparam logic [1:0] CSR_SCROLL_STEP = 2'd0;
   localparam logic [1:0] CSR_PHRASE_END  = 2'd1;
   localparam logic [1:0] CSR_STATIC_HOLD = 2'd2;

   localparam int FLAG_FIRST_BIT   = 0;
   localparam int FLAG_LAST_BIT    = 1;
   localparam int FLAG_PENDING_BIT = 2;

   localparam logic [7:0] IDLE_TICKS        = 8'd6;
   localparam logic [7:0] SCROLL_STEP_RESET = 8'd6;
   localparam logic [7:0] PHRASE_END_RESET  = 8'd12;
   localparam logic [7:0] STATIC_HOLD_RESET = 8'd12;

   typedef struct packed {
      logic apply;
      logic col_clear;
      logic read;
      logic col_next;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic frame_start;
      logic last_col;
   } ctrl_status_type;

endpackage

`default_nettype wire

### rtl/core/lmsr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module lmsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 192
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/lmsr_ctrl.sv
// Controller state machine: accepts items and sequences frame columns.
// Depends on lmsr_pkg.
`default_nettype none

module lmsr_ctrl import lmsr_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output ctrl_cmd_type         cmd,
   input  wire ctrl_status_type status
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_stall = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_SHOW);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (status.frame_start) begin
                  cmd.col_clear = 1'b1;
                  state_in      = ST_READ;
               end else begin
                  cmd.apply = 1'b1;
               end
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            if (!rsp_stall) begin
               if (status.last_col) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end else begin
                  cmd.col_next = 1'b1;
                  state_in     = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/core/lmsr_datapath.sv
// Datapath: marquee state, configuration registers, column RAM and frame column selection.
// Depends on lmsr_pkg and lmsr_ram.
`default_nettype none

module lmsr_datapath import lmsr_pkg::*; #(
   parameter int DISPLAY_WIDTH = 32,
   parameter int BUFFER_DEPTH  = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire ctrl_cmd_type cmd,
   output ctrl_status_type   status,
   input  wire logic [1:0]   req_opcode,
   input  wire logic [7:0]   req_column_in,
   input  wire logic         req_first_part,
   input  wire logic         req_last_part,
   input  wire logic         csr_write_enable,
   input  wire logic [1:0]   csr_index,
   input  wire logic [7:0]   csr_write_data,
   output logic      [7:0]   rsp_column_out,
   output logic              rsp_frame_end
);

   localparam int CW = $clog2(DISPLAY_WIDTH + 1);
   localparam int SW = $clog2(BUFFER_DEPTH + 1);
   localparam int NW = ((CW > SW) ? CW : SW) + 1;
   localparam int RAM_DEPTH = 3 * BUFFER_DEPTH;
   localparam int AW = $clog2(RAM_DEPTH);
   localparam logic [NW-1:0] W_N = NW'(DISPLAY_WIDTH);
   localparam logic [SW-1:0] DEPTH_S = SW'(BUFFER_DEPTH);
   localparam logic [AW-1:0] BASE1 = AW'(BUFFER_DEPTH);
   localparam logic [AW-1:0] BASE2 = AW'(2 * BUFFER_DEPTH);
   localparam logic [1:0] BANK0 = 2'd0;
   localparam logic [1:0] BANK1 = 2'd1;
   localparam logic [1:0] BANK2 = 2'd2;

   function automatic logic [AW-1:0] bank_base(input logic [1:0] bank);
      logic [AW-1:0] base;
      base = '0;
      if (bank == BANK1) begin
         base = BASE1;
      end else if (bank == BANK2) begin
         base = BASE2;
      end
      return base;
   endfunction

   mode_type         mode_ff, mode_in;
   logic [SW-1:0]    size_a_ff, size_a_in, size_b_ff, size_b_in;
   logic [1:0]       flags_a_ff, flags_a_in, flags_b_ff, flags_b_in;
   logic [1:0]       bank_a_ff, bank_a_in, bank_b_ff, bank_b_in, stg_bank_ff, stg_bank_in;
   logic [SW-1:0]    stg_cnt_ff, stg_cnt_in;
   logic [2:0]       stg_flags_ff, stg_flags_in;
   logic [CW-1:0]    lead_ff, lead_in;
   logic [SW-1:0]    scroll_ff, scroll_in;
   logic [7:0]       ticks_ff, ticks_in;
   logic [7:0]       scroll_step_ff, phrase_end_ff, static_hold_ff;
   logic [CW-1:0]    col_ff, col_in;
   logic             blank_q_ff, end_q_ff;

   logic             pending;
   logic             load_ok;
   logic             blank;
   logic [AW-1:0]    rd_addr;
   logic [AW-1:0]    wr_addr;
   logic             wr_en;
   logic [7:0]       ram_q;

   assign pending = stg_flags_ff[FLAG_PENDING_BIT];
   assign load_ok = !pending && (stg_cnt_ff < DEPTH_S);
   assign wr_en   = cmd.apply && (req_opcode == OP_LOAD) && load_ok;
   assign wr_addr = bank_base(stg_bank_ff) + AW'(stg_cnt_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_EMPTY;
         size_a_ff      <= '0;
         size_b_ff      <= '0;
         flags_a_ff     <= '0;
         flags_b_ff     <= '0;
         bank_a_ff      <= BANK0;
         bank_b_ff      <= BANK1;
         stg_bank_ff    <= BANK2;
         stg_cnt_ff     <= '0;
         stg_flags_ff   <= '0;
         lead_ff        <= '0;
         scroll_ff      <= '0;
         ticks_ff       <= IDLE_TICKS;
         scroll_step_ff <= SCROLL_STEP_RESET;
         phrase_end_ff  <= PHRASE_END_RESET;
         static_hold_ff <= STATIC_HOLD_RESET;
         col_ff         <= '0;
      end else begin
         mode_ff      <= mode_in;
         size_a_ff    <= size_a_in;
         size_b_ff    <= size_b_in;
         flags_a_ff   <= flags_a_in;
         flags_b_ff   <= flags_b_in;
         bank_a_ff    <= bank_a_in;
         bank_b_ff    <= bank_b_in;
         stg_bank_ff  <= stg_bank_in;
         stg_cnt_ff   <= stg_cnt_in;
         stg_flags_ff <= stg_flags_in;
         lead_ff      <= lead_in;
         scroll_ff    <= scroll_in;
         ticks_ff     <= ticks_in;
         col_ff       <= col_in;
         if (csr_write_enable) begin
            if (csr_index == CSR_SCROLL_STEP) begin
               scroll_step_ff <= csr_write_data;
            end else if (csr_index == CSR_PHRASE_END) begin
               phrase_end_ff <= csr_write_data;
            end else if (csr_index == CSR_STATIC_HOLD) begin
               static_hold_ff <= csr_write_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         blank_q_ff <= blank;
         end_q_ff   <= (col_ff == CW'(DISPLAY_WIDTH - 1));
      end
   end

   always_comb begin
      if (cmd.col_clear) begin
         col_in = '0;
      end else if (cmd.col_next) begin
         col_in = col_ff + 1'b1;
      end else begin
         col_in = col_ff;
      end
   end

   // Buffers A and B are kept relative to the active one, so a swap exchanges them.
   // The staged matrix moves into a buffer by exchanging bank numbers.
   always_comb begin
      logic do_move;
      logic cont;
      logic [SW-1:0] new_size;
      logic [1:0] new_flags;
      mode_in      = mode_ff;
      size_a_in    = size_a_ff;
      size_b_in    = size_b_ff;
      flags_a_in   = flags_a_ff;
      flags_b_in   = flags_b_ff;
      bank_a_in    = bank_a_ff;
      bank_b_in    = bank_b_ff;
      stg_bank_in  = stg_bank_ff;
      stg_cnt_in   = stg_cnt_ff;
      stg_flags_in = stg_flags_ff;
      lead_in      = lead_ff;
      scroll_in    = scroll_ff;
      ticks_in     = ticks_ff;
      do_move      = 1'b0;
      cont         = 1'b1;
      new_size     = size_a_ff;
      new_flags    = flags_a_ff;

      if (cmd.apply) begin
         unique case (req_opcode)
            OP_LOAD: begin
               if (load_ok) begin
                  stg_cnt_in = stg_cnt_ff + 1'b1;
               end
            end
            OP_COMMIT: begin
               if (!pending && stg_cnt_ff != '0) begin
                  stg_flags_in = {1'b1, req_last_part, req_first_part};
               end
            end
            OP_TICK: begin
               if (ticks_ff != '0) begin
                  ticks_in = ticks_ff - 1'b1;
               end else begin
                  do_move = 1'b1;
                  if (mode_ff == MODE_EMPTY) begin
                     if (size_a_ff == '0 && size_b_ff == '0) begin
                        ticks_in = IDLE_TICKS;
                     end else begin
                        if (size_a_ff == '0) begin
                           size_a_in  = size_b_ff;
                           flags_a_in = flags_b_ff;
                           bank_a_in  = bank_b_ff;
                           size_b_in  = size_a_ff;
                           flags_b_in = flags_a_ff;
                           bank_b_in  = bank_a_ff;
                           new_size   = size_b_ff;
                           new_flags  = flags_b_ff;
                        end
                        if (NW'(new_size) <= W_N) begin
                           mode_in = MODE_STABLE;
                        end else begin
                           mode_in   = MODE_PIXEL;
                           lead_in   = new_flags[FLAG_FIRST_BIT] ? CW'(DISPLAY_WIDTH) : '0;
                           scroll_in = '0;
                        end
                        ticks_in = '0;
                     end
                  end else begin
                     mode_in   = MODE_EMPTY;
                     lead_in   = '0;
                     scroll_in = '0;
                     ticks_in  = IDLE_TICKS;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.finish) begin
         do_move = 1'b1;
         if (mode_ff == MODE_STABLE) begin
            size_a_in  = '0;
            flags_a_in = '0;
            mode_in    = MODE_RENDERED;
            ticks_in   = static_hold_ff;
         end else begin
            if (lead_ff != '0) begin
               lead_in = lead_ff - 1'b1;
            end else if (scroll_ff < size_a_ff) begin
               scroll_in = scroll_ff + 1'b1;
            end else if (flags_a_ff[FLAG_LAST_BIT]) begin
               size_a_in  = '0;
               flags_a_in = '0;
               cont       = 1'b0;
            end else begin
               size_a_in  = size_b_ff;
               flags_a_in = flags_b_ff;
               bank_a_in  = bank_b_ff;
               size_b_in  = '0;
               flags_b_in = '0;
               bank_b_in  = bank_a_ff;
               scroll_in  = '0;
               cont       = (size_b_ff != '0);
            end
            if (!cont) begin
               mode_in = MODE_RENDERED;
            end
            ticks_in = cont ? scroll_step_ff : phrase_end_ff;
         end
      end

      if (do_move && pending) begin
         if (size_a_in == '0) begin
            stg_bank_in  = bank_a_in;
            bank_a_in    = stg_bank_ff;
            size_a_in    = stg_cnt_ff;
            flags_a_in   = stg_flags_ff[1:0];
            stg_cnt_in   = '0;
            stg_flags_in = '0;
         end else if (size_b_in == '0) begin
            stg_bank_in  = bank_b_in;
            bank_b_in    = stg_bank_ff;
            size_b_in    = stg_cnt_ff;
            flags_b_in   = stg_flags_ff[1:0];
            stg_cnt_in   = '0;
            stg_flags_in = '0;
         end
      end
   end

   // Source of the current frame column: leading blanks, A columns, B columns, blanks.
   always_comb begin
      logic stable;
      logic use_b;
      logic [NW-1:0] sa, sb, fit, lead_v, room, scr, avail, na, rem, nb, col_v, off, off_b;
      stable = (mode_ff == MODE_STABLE);
      sa     = NW'(size_a_ff);
      sb     = NW'(size_b_ff);
      fit    = (sa > W_N) ? W_N : sa;
      if (stable) begin
         lead_v = (W_N - fit) >> 1;
         scr    = '0;
      end else begin
         lead_v = NW'(lead_ff);
         scr    = NW'(scroll_ff);
      end
      room  = W_N - lead_v;
      avail = (sa > scr) ? (sa - scr) : '0;
      na    = (avail < room) ? avail : room;
      use_b = !stable && (na < room) && !flags_a_ff[FLAG_LAST_BIT] && (sb != '0);
      rem   = room - na;
      nb    = (rem < sb) ? rem : sb;
      col_v = NW'(col_ff);
      off   = col_v - lead_v;
      off_b = off - na;
      blank   = 1'b1;
      rd_addr = '0;
      if (col_v >= lead_v) begin
         if (off < na) begin
            blank   = 1'b0;
            rd_addr = bank_base(bank_a_ff) + AW'(scr + off);
         end else if (use_b && off_b < nb) begin
            blank   = 1'b0;
            rd_addr = bank_base(bank_b_ff) + AW'(off_b);
         end
      end
   end

   lmsr_ram #(
      .WIDTH (8),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_column_in),
      .rd_en   (cmd.read),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign status.frame_start = (req_opcode == OP_TICK) && (ticks_ff == '0)
                               && (mode_ff == MODE_STABLE || mode_ff == MODE_PIXEL);
   assign status.last_col    = end_q_ff;
   assign rsp_column_out     = blank_q_ff ? 8'd0 : ram_q;
   assign rsp_frame_end      = end_q_ff;

endmodule

`default_nettype wire

### rtl/core/led_matrix_scroll_renderer.sv
// Top level of the LED matrix scroll renderer: controller, datapath and column RAM.
// Load, commit and non-rendering tick items are applied in idle without a stall.
// A tick that renders a frame stalls requests while each column is read from the
// column RAM in ST_READ, registered and shown in ST_SHOW, which holds on rsp_stall.
// Synchronous active-high reset restores the register defaults and empty buffers;
// the column RAM is not cleared and needs no clearing pass.
`default_nettype none

module led_matrix_scroll_renderer import lmsr_pkg::*; #(
   parameter int DISPLAY_WIDTH = 32,
   parameter int BUFFER_DEPTH  = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_opcode,
   input  wire logic [7:0] req_column_in,
   input  wire logic       req_first_part,
   input  wire logic       req_last_part,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic      [7:0] rsp_column_out,
   output logic            rsp_frame_end,
   input  wire logic       csr_write_enable,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_write_data
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   lmsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   lmsr_datapath #(
      .DISPLAY_WIDTH (DISPLAY_WIDTH),
      .BUFFER_DEPTH  (BUFFER_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_opcode       (req_opcode),
      .req_column_in    (req_column_in),
      .req_first_part   (req_first_part),
      .req_last_part    (req_last_part),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_column_out   (rsp_column_out),
      .rsp_frame_end    (rsp_frame_end)
   );

endmodule

`default_nettype wire

### bench/lmsr_checker.sv
// Checker for the LED matrix scroll renderer: watches request, response and register
// transfers, predicts the frames each tick produces and compares them column by column.
// Depends on lmsr_pkg.
`default_nettype none

module lmsr_checker import lmsr_pkg::*; #(
   parameter int DISPLAY_WIDTH = 32,
   parameter int BUFFER_DEPTH  = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_stall,
   input  wire logic [1:0] req_opcode,
   input  wire logic [7:0] req_column_in,
   input  wire logic       req_first_part,
   input  wire logic       req_last_part,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_stall,
   input  wire logic [7:0] rsp_column_out,
   input  wire logic       rsp_frame_end,
   input  wire logic       csr_write_enable,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_write_data,
   output int              fail_count,
   output int              pending_columns
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] column;
      logic       frame_end;
   } column_type;

   column_type column_queue[$];

   logic [7:0] step_delay, end_delay, hold_delay;
   mode_type   mode;
   logic [7:0] buf_cols[2][BUFFER_DEPTH];
   int         buf_size[2];
   logic [1:0] buf_flags[2];
   logic       sel;
   logic [7:0] stage_cols[BUFFER_DEPTH];
   int         stage_count;
   logic [2:0] stage_flags;
   int         lead_blanks, scroll_pos;
   logic [7:0] ticks_left;

   assign pending_columns = column_queue.size();

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   task automatic push_frame(input logic [7:0] frame[DISPLAY_WIDTH]);
      column_type c;
      for (int i = 0; i < DISPLAY_WIDTH; i++) begin
         c.column = frame[i];
         c.frame_end = (i == DISPLAY_WIDTH - 1);
         column_queue.push_back(c);
      end
   endtask

   function automatic logic [7:0] read_col(input logic s, input int i);
      if (i >= BUFFER_DEPTH) return 8'd0;
      return buf_cols[s][i];
   endfunction

   function automatic bit advance_scroll();
      logic [1:0] fl;
      if (lead_blanks > 0) begin
         lead_blanks--;
         return 1;
      end
      if (scroll_pos < buf_size[sel]) begin
         scroll_pos++;
         return 1;
      end
      fl = buf_flags[sel];
      buf_size[sel] = 0;
      buf_flags[sel] = 0;
      if (fl[FLAG_LAST_BIT]) return 0;
      sel = ~sel;
      scroll_pos = 0;
      return buf_size[sel] != 0;
   endfunction

   task automatic render_tick();
      logic [7:0] frame[DISPLAY_WIDTH];
      int n, first, room, avail, na, nb;
      foreach (frame[i]) frame[i] = 8'd0;
      case (mode)
         MODE_EMPTY: begin
            if (buf_size[0] == 0 && buf_size[1] == 0) begin
               ticks_left = IDLE_TICKS;
            end else begin
               if (buf_size[sel] == 0) sel = ~sel;
               if (buf_size[sel] <= DISPLAY_WIDTH) begin
                  mode = MODE_STABLE;
               end else begin
                  mode = MODE_PIXEL;
                  lead_blanks = buf_flags[sel][FLAG_FIRST_BIT] ? DISPLAY_WIDTH : 0;
                  scroll_pos = 0;
               end
               ticks_left = 0;
            end
         end
         MODE_STABLE: begin
            n = buf_size[sel] > DISPLAY_WIDTH ? DISPLAY_WIDTH : buf_size[sel];
            first = (DISPLAY_WIDTH - n) / 2;
            for (int i = 0; i < n; i++) frame[first + i] = read_col(sel, i);
            buf_size[sel] = 0;
            buf_flags[sel] = 0;
            mode = MODE_RENDERED;
            ticks_left = hold_delay;
            push_frame(frame);
         end
         MODE_PIXEL: begin
            first = lead_blanks > DISPLAY_WIDTH ? DISPLAY_WIDTH : lead_blanks;
            room = DISPLAY_WIDTH - first;
            avail = scroll_pos < buf_size[sel] ? buf_size[sel] - scroll_pos : 0;
            na = avail < room ? avail : room;
            for (int i = 0; i < na; i++) frame[first + i] = read_col(sel, scroll_pos + i);
            if (na < room && !buf_flags[sel][FLAG_LAST_BIT] && buf_size[~sel] != 0) begin
               nb = room - na;
               if (nb > buf_size[~sel]) nb = buf_size[~sel];
               for (int i = 0; i < nb; i++) frame[first + na + i] = read_col(~sel, i);
            end
            push_frame(frame);
            if (!advance_scroll()) mode = MODE_RENDERED;
            ticks_left = (mode == MODE_RENDERED) ? end_delay : step_delay;
         end
         default: begin
            mode = MODE_EMPTY;
            lead_blanks = 0;
            scroll_pos = 0;
            ticks_left = IDLE_TICKS;
         end
      endcase
   endtask

   task automatic move_staged();
      logic dst;
      if (!stage_flags[FLAG_PENDING_BIT]) return;
      if (buf_size[sel] == 0) dst = sel;
      else if (buf_size[~sel] == 0) dst = ~sel;
      else return;
      for (int i = 0; i < stage_count; i++) buf_cols[dst][i] = stage_cols[i];
      buf_size[dst] = stage_count;
      buf_flags[dst] = stage_flags[1:0];
      stage_count = 0;
      stage_flags = 3'd0;
   endtask

   task automatic apply_request(input logic [1:0] op, input logic [7:0] col,
                                input logic fp, input logic lp);
      case (op)
         OP_LOAD: begin
            if (!stage_flags[FLAG_PENDING_BIT] && stage_count < BUFFER_DEPTH) begin
               stage_cols[stage_count] = col;
               stage_count++;
            end
         end
         OP_COMMIT: begin
            if (!stage_flags[FLAG_PENDING_BIT] && stage_count != 0)
               stage_flags = {1'b1, lp, fp};
         end
         OP_TICK: begin
            if (ticks_left > 0) begin
               ticks_left--;
            end else begin
               render_tick();
               move_staged();
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      column_type exp_col;
      if (reset) begin
         step_delay <= SCROLL_STEP_RESET;
         end_delay <= PHRASE_END_RESET;
         hold_delay <= STATIC_HOLD_RESET;
         mode <= MODE_EMPTY;
         buf_size <= '{0, 0};
         buf_flags <= '{2'd0, 2'd0};
         sel <= 1'b0;
         stage_count <= 0;
         stage_flags <= 3'd0;
         lead_blanks <= 0;
         scroll_pos <= 0;
         ticks_left <= IDLE_TICKS;
         column_queue.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_SCROLL_STEP: step_delay = csr_write_data;
               CSR_PHRASE_END:  end_delay = csr_write_data;
               CSR_STATIC_HOLD: hold_delay = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            apply_request(req_opcode, req_column_in, req_first_part, req_last_part);
         if (rsp_valid && !rsp_stall) begin
            if (column_queue.size() == 0) begin
               report_mismatch($sformatf("unexpected column %h", rsp_column_out));
            end else begin
               exp_col = column_queue.pop_front();
               if (rsp_column_out !== exp_col.column)
                  report_mismatch($sformatf("column_out %h, expected %h",
                                            rsp_column_out, exp_col.column));
               if (rsp_frame_end !== exp_col.frame_end)
                  report_mismatch($sformatf("frame_end %b, expected %b",
                                            rsp_frame_end, exp_col.frame_end));
            end
         end
      end
   end

   initial fail_count = 0;

endmodule

`default_nettype wire

### bench/tb_top.sv
// Top of the LED matrix scroll renderer testbench: clock, reset, stimulus with random
// idling and stalls, register phases and the verdict. Depends on lmsr_pkg,
// lmsr_checker and led_matrix_scroll_renderer.
`default_nettype none

module tb_top;
   import lmsr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT = 400000;
   localparam logic [1:0] OP_UNUSED  = 2'd3;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   logic       clock, reset;
   logic       req_valid, req_stall;
   logic [1:0] req_opcode;
   logic [7:0] req_column_in;
   logic       req_first_part, req_last_part;
   logic       rsp_valid, rsp_stall;
   logic [7:0] rsp_column_out;
   logic       rsp_frame_end;
   logic       csr_write_enable;
   logic [1:0] csr_index;
   logic [7:0] csr_write_data;
   int         fail_count, pending_columns, cycles;
   bit         quiet;

   led_matrix_scroll_renderer dut (.*);
   lmsr_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > LIMIT) begin
            $display("led_matrix_scroll_renderer test failed");
            $finish;
         end
      end
   end

   // Receiver stalls come in short random bursts until the quiet tail of the run.
   initial begin
      int burst;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (burst > 0) begin
            burst--;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 4);
         end
         rsp_stall <= (burst > 0);
      end
   end

   task automatic send(input logic [1:0] op, input logic [7:0] col,
                       input logic fp, input logic lp);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_column_in <= col;
      req_first_part <= fp;
      req_last_part <= lp;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_columns != 0) @(posedge clock);
      repeat (4 * 32 + 10) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_phrase(input int len, input logic fp, input logic lp);
      for (int i = 0; i < len; i++) send(OP_LOAD, 8'($urandom), 1'b0, 1'b0);
      send(OP_COMMIT, 8'($urandom), fp, lp);
   endtask

   task automatic send_ticks(input int n);
      for (int i = 0; i < n; i++) send(OP_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
   endtask

   initial begin
      quiet = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_TICK;
      req_column_in = 8'd0;
      req_first_part = 1'b0;
      req_last_part = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = CSR_SCROLL_STEP;
      csr_write_data = 8'd0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: an ignored empty commit, a load during a pending commit, the
      // unused opcode, a short stable phrase, then a full staging buffer with a
      // dropped load that scrolls in from blank and hands over to a short last part.
      write_reg(CSR_SCROLL_STEP, 8'd0);
      write_reg(CSR_PHRASE_END, 8'd0);
      write_reg(CSR_STATIC_HOLD, 8'd0);
      write_reg(CSR_UNUSED, 8'hff);
      send(OP_COMMIT, 8'h00, 1'b1, 1'b1);
      send(OP_LOAD, 8'h00, 1'b0, 1'b0);
      send(OP_LOAD, 8'hff, 1'b0, 1'b0);
      send(OP_COMMIT, 8'h00, 1'b0, 1'b0);
      send(OP_LOAD, 8'haa, 1'b0, 1'b0);
      send(OP_UNUSED, 8'h55, 1'b1, 1'b1);
      send_ticks(16);
      send_phrase(65, 1'b1, 1'b0);
      send_ticks(7);
      send_phrase(3, 1'b0, 1'b1);
      send_ticks(110);
      wait_idle();

      // Random phases with short phrases and small register settings.
      for (int phase = 0; phase < 2; phase++) begin
         write_reg(CSR_SCROLL_STEP, 8'($urandom_range(0, 2)));
         write_reg(CSR_PHRASE_END, 8'($urandom_range(0, 3)));
         write_reg(CSR_STATIC_HOLD, 8'($urandom_range(0, 3)));
         if (phase == 1) quiet = 1'b1;
         repeat (2) begin
            send_phrase($urandom_range(1, 8), 1'($urandom), 1'($urandom));
            send_ticks($urandom_range(8, 12));
         end
         send_ticks(8);
         wait_idle();
      end

      if (fail_count == 0)
         $display("led_matrix_scroll_renderer test passed");
      else
         $display("led_matrix_scroll_renderer test failed");
      $finish;
   end

endmodule

`default_nettype wire
